// ===== design/front_panel_step_trap_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Front-panel step and trap controller: assertion macros
// Shared macros for the concurrent checks in the controller RTL.
// ----------------------------------------------------------------------------
`ifndef FRONT_PANEL_STEP_TRAP_CONTROLLER_DEFINES_SVH
`define FRONT_PANEL_STEP_TRAP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FPSTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FPSTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fpstc_pkg.sv =====
// ----------------------------------------------------------------------------
// Front-panel step and trap controller: package
// Event codes, line action codes and the transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package fpstc_pkg;

	// Width of the address fields on the ports.
	localparam int AddrW = 14;
	// Number of address bits that take part in capture and trap compare.
	localparam int AddressBits = 14;
	localparam logic [AddrW-1:0] AddrMask = AddrW'((64'd1 << AddressBits) - 64'd1);

	// Configuration register indexes.
	localparam logic [1:0] CFG_START_AUTOMATIC = 2'd0;
	localparam logic [1:0] CFG_SWITCH_VALUE    = 2'd1;
	localparam logic [1:0] CFG_TRAP_ADDRESS    = 2'd2;

	// Event codes.
	typedef enum logic [3:0] {
		OP_POWER   = 4'd0,
		OP_AUTO    = 4'd1,
		OP_STEP    = 4'd2,
		OP_TRAP    = 4'd3,
		OP_INSTR   = 4'd4,
		OP_CYCLE   = 4'd5,
		OP_SUBST   = 4'd6,
		OP_ADVANCE = 4'd7,
		OP_SYNC    = 4'd8,
		OP_CLOCK   = 4'd9,
		OP_SUB     = 4'd10,
		OP_ACK     = 4'd11,
		OP_IRQ     = 4'd12
	} op_t;

	// Ready and substitute line actions.
	localparam logic [1:0] LINE_KEEP = 2'd0;
	localparam logic [1:0] LINE_LOW  = 2'd1;
	localparam logic [1:0] LINE_HIGH = 2'd2;

	// Data bus actions.
	localparam logic [1:0] BUS_NONE    = 2'd0;
	localparam logic [1:0] BUS_DRIVE   = 2'd1;
	localparam logic [1:0] BUS_RELEASE = 2'd2;

	// Interrupt line actions.
	localparam logic [1:0] INT_KEEP    = 2'd0;
	localparam logic [1:0] INT_CLAIM   = 2'd1;
	localparam logic [1:0] INT_RELEASE = 2'd2;

	// Run mode codes.
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_AUTO = 2'd1;
	localparam logic [1:0] MODE_STEP = 2'd2;

	// Cycle type on the bus; the captured kind is this code plus one.
	localparam logic [1:0] CTYPE_FETCH = 2'd0;

	typedef struct packed {
		logic [3:0]       opcode;
		logic             rising;
		logic [1:0]       cycle_type;
		logic             t2_high;
		logic             sync_high;
		logic             t3prime_high;
		logic [AddrW-1:0] bus_address;
		logic [7:0]       bus_data;
		logic             wait_high;
		logic             stop_high;
		logic             sub_high;
		logic             init_high;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       ready_action;
		logic [1:0]       bus_action;
		logic [7:0]       bus_value;
		logic [1:0]       sub_action;
		logic [1:0]       init_action;
		logic [1:0]       run_mode;
		logic [2:0]       panel_flags;
		logic [1:0]       cpu_flags;
		logic [2:0]       cycle_kind;
		logic [AddrW-1:0] captured_address;
		logic [7:0]       captured_data;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/front_panel_step_trap_controller.sv =====
// ----------------------------------------------------------------------------
// Front-panel step and trap controller
// Keeps run mode, step granularity, trap and substitution state for an 8-bit
// processor bus and answers each bus or panel event with line actions.
//
// Usage:
// - The in channel carries one event per transaction with the bus levels
//   sampled at that moment; the out channel returns exactly one result
//   transaction per event, in order.
// - The cfg channel writes start_automatic (0), switch_value (1) and
//   trap_address (2); other indexes are ignored. cfg_ready is always high.
// - The result of an event accepted at one edge is valid after that edge.
//   Throughput is one event per cycle while the receiver takes results, set
//   by the single result register; the state update for an event completes
//   at the edge that accepts it, so the next event may follow directly.
// - If the receiver stalls, the result register holds its transaction and
//   in_ready stays high only while that register is being emptied.
// - Reset clears all panel state, the configuration registers and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

`include "front_panel_step_trap_controller_defines.svh"

module front_panel_step_trap_controller
	import fpstc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [AddrW-1:0] cfg_data
);

	// Configuration registers.
	logic             start_automatic_q;
	logic [7:0]       switch_value_q;
	logic [AddrW-1:0] trap_address_q;

	// Panel state.
	logic             auto_run_q, step_run_q, trap_on_q, by_cycle_q, subst_on_q;
	logic             release_pending_q, irq_pending_q;
	logic [1:0]       cpu_status_q;
	logic [2:0]       last_cycle_q;
	logic [AddrW-1:0] held_address_q;
	logic [7:0]       held_data_q;

	// Next state.
	logic             auto_run_d, step_run_d, trap_on_d, by_cycle_d, subst_on_d;
	logic             release_pending_d, irq_pending_d;
	logic [1:0]       cpu_status_d;
	logic [2:0]       last_cycle_d;
	logic [AddrW-1:0] held_address_d;
	logic [7:0]       held_data_d;

	// Result register.
	logic      out_valid_q;
	out_item_t out_data_q;
	out_item_t result;

	logic             in_fire, cfg_fire;
	logic [AddrW-1:0] addr_m;
	logic             fetch;
	logic [1:0]       ready_act, bus_act, sub_act, init_act;
	logic [7:0]       bus_val;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign addr_m = in_data.bus_address & AddrMask;
	assign fetch  = (in_data.cycle_type == CTYPE_FETCH);

	// Event decode: next panel state and the line actions for this event.
	always_comb begin
		auto_run_d        = auto_run_q;
		step_run_d        = step_run_q;
		trap_on_d         = trap_on_q;
		by_cycle_d        = by_cycle_q;
		subst_on_d        = subst_on_q;
		release_pending_d = release_pending_q;
		irq_pending_d     = irq_pending_q;
		cpu_status_d      = cpu_status_q;
		last_cycle_d      = last_cycle_q;
		held_address_d    = held_address_q;
		held_data_d       = held_data_q;
		ready_act         = LINE_KEEP;
		bus_act           = BUS_NONE;
		bus_val           = 8'd0;
		sub_act           = LINE_KEEP;
		init_act          = INT_KEEP;

		unique case (in_data.opcode)
			OP_POWER: begin
				if (in_data.rising) begin
					if (start_automatic_q) begin
						auto_run_d = 1'b1;
						step_run_d = 1'b0;
						ready_act  = LINE_HIGH;
					end else begin
						auto_run_d = 1'b0;
						step_run_d = 1'b1;
					end
				end
			end
			OP_AUTO: begin
				auto_run_d = 1'b1;
				step_run_d = 1'b0;
				ready_act  = LINE_HIGH;
			end
			OP_STEP: begin
				auto_run_d = 1'b0;
				step_run_d = 1'b1;
			end
			OP_TRAP:  trap_on_d  = !trap_on_q;
			OP_INSTR: by_cycle_d = 1'b0;
			OP_CYCLE: by_cycle_d = 1'b1;
			OP_SUBST: begin
				subst_on_d = !subst_on_q;
				// Turning substitution off while the line is held asks for a release.
				if (in_data.sub_high) begin
					release_pending_d = subst_on_q;
				end
			end
			OP_ADVANCE: begin
				if (step_run_q) begin
					ready_act = LINE_HIGH;
				end
			end
			OP_SYNC: begin
				cpu_status_d = {in_data.stop_high, in_data.wait_high};
				if (!in_data.rising) begin
					if (release_pending_q) begin
						bus_act           = BUS_RELEASE;
						release_pending_d = 1'b0;
					end else if (in_data.sub_high) begin
						bus_act = BUS_DRIVE;
						bus_val = switch_value_q;
					end
					sub_act = subst_on_q ? LINE_HIGH : LINE_LOW;
				end
			end
			OP_CLOCK: begin
				if (!in_data.rising) begin
					// Address phase: capture the cycle and decide on a stop.
					if (in_data.t2_high && !in_data.sync_high) begin
						last_cycle_d   = {1'b0, in_data.cycle_type} + 3'd1;
						held_address_d = addr_m;
						if (step_run_q) begin
							if (by_cycle_q || fetch) begin
								ready_act = LINE_LOW;
							end else begin
								ready_act = LINE_HIGH;
							end
						end else if (trap_on_q && fetch &&
								addr_m == (trap_address_q & AddrMask)) begin
							ready_act  = LINE_LOW;
							auto_run_d = 1'b0;
							step_run_d = 1'b1;
						end
					end
					if (in_data.t3prime_high) begin
						held_data_d = in_data.bus_data;
					end
				end else if (irq_pending_q) begin
					init_act      = INT_CLAIM;
					irq_pending_d = 1'b0;
				end
			end
			OP_SUB: begin
				if (in_data.rising) begin
					bus_act = BUS_DRIVE;
					bus_val = switch_value_q;
				end
			end
			OP_ACK: begin
				if (!in_data.rising && in_data.init_high) begin
					init_act = INT_RELEASE;
				end
			end
			OP_IRQ:  irq_pending_d = 1'b1;
			default: begin
			end
		endcase
	end

	// Result transaction: actions plus status after the update.
	always_comb begin
		result.ready_action     = ready_act;
		result.bus_action       = bus_act;
		result.bus_value        = bus_val;
		result.sub_action       = sub_act;
		result.init_action      = init_act;
		result.run_mode         = auto_run_d ? MODE_AUTO :
			(step_run_d ? MODE_STEP : MODE_NONE);
		result.panel_flags      = {subst_on_d, by_cycle_d, trap_on_d};
		result.cpu_flags        = cpu_status_d;
		result.cycle_kind       = last_cycle_d;
		result.captured_address = held_address_d;
		result.captured_data    = held_data_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_automatic_q <= 1'b0;
			switch_value_q    <= 8'd0;
			trap_address_q    <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_START_AUTOMATIC: start_automatic_q <= cfg_data[0];
				CFG_SWITCH_VALUE:    switch_value_q    <= cfg_data[7:0];
				CFG_TRAP_ADDRESS:    trap_address_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Panel state, updated at the edge that accepts an event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_run_q        <= 1'b0;
			step_run_q        <= 1'b0;
			trap_on_q         <= 1'b0;
			by_cycle_q        <= 1'b0;
			subst_on_q        <= 1'b0;
			release_pending_q <= 1'b0;
			irq_pending_q     <= 1'b0;
			cpu_status_q      <= 2'd0;
			last_cycle_q      <= 3'd0;
			held_address_q    <= '0;
			held_data_q       <= 8'd0;
		end else if (in_fire) begin
			auto_run_q        <= auto_run_d;
			step_run_q        <= step_run_d;
			trap_on_q         <= trap_on_d;
			by_cycle_q        <= by_cycle_d;
			subst_on_q        <= subst_on_d;
			release_pending_q <= release_pending_d;
			irq_pending_q     <= irq_pending_d;
			cpu_status_q      <= cpu_status_d;
			last_cycle_q      <= last_cycle_d;
			held_address_q    <= held_address_d;
			held_data_q       <= held_data_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= result;
		end
	end

	// Checks on the controller state and result register.
	`FPSTC_ASSERT_NOW(a_mode_exclusive, 1'b1, !(auto_run_q && step_run_q), "both run modes set")
	`FPSTC_ASSERT_NEXT(a_accept_gives_result, in_fire, out_valid_q, "accepted event gave no result")
	`FPSTC_ASSERT_NOW(a_bus_value_idle, out_valid_q && out_data_q.bus_action != BUS_DRIVE,
		out_data_q.bus_value == 8'd0, "bus value set without a drive action")
	`FPSTC_ASSERT_NEXT(a_irq_latched, in_fire && in_data.opcode == OP_IRQ, irq_pending_q,
		"interrupt request not latched")
	`FPSTC_ASSERT_NEXT(a_trap_cfg, cfg_fire && cfg_index == CFG_TRAP_ADDRESS,
		trap_address_q == $past(cfg_data), "trap address write lost")

endmodule

`default_nettype wire
